### sv/dps_pkg.sv
`timescale 1ns / 1ps
// Shared types, register map and lane helpers for the delta prefix-sum decoder.
// No dependencies.
package dps_pkg;

    localparam int WORD_W  = 64;
    localparam int BYTES_W = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register index as decoded from paddr[2]
    localparam logic REG_LANE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        LANE_1B,
        LANE_2B,
        LANE_4B,
        LANE_8B
    } lane_size_t;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        lane_size_t        code;
        logic              first;
        logic              last;
    } stage_t;

    // true where byte idx opens a new lane
    function automatic logic lane_start(input lane_size_t code, input logic [2:0] idx);
        logic r;
        begin
            unique case (code)
                LANE_1B: r = 1'b1;
                LANE_2B: r = (idx[0] == 1'b0);
                LANE_4B: r = (idx[1:0] == 2'b00);
                LANE_8B: r = (idx == 3'd0);
                default: r = 1'b1;
            endcase
            return r;
        end
    endfunction

    // top lane of a word, zero-extended
    function automatic logic [WORD_W-1:0] last_lane(input logic [WORD_W-1:0] w,
                                                    input lane_size_t code);
        logic [WORD_W-1:0] r;
        begin
            unique case (code)
                LANE_1B: r = {56'd0, w[63:56]};
                LANE_2B: r = {48'd0, w[63:48]};
                LANE_4B: r = {32'd0, w[63:32]};
                LANE_8B: r = w;
                default: r = w;
            endcase
            return r;
        end
    endfunction

endpackage

### sv/dps_in_if.sv
`timescale 1ns / 1ps
// Input channel: one delta word per beat with block framing flags.
// No dependencies.
interface dps_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] delta_word;
    logic        first_word;
    logic        last_word;

    modport source (output valid, output delta_word, output first_word,
                    output last_word, input ready);
    modport sink   (input valid, input delta_word, input first_word,
                    input last_word, output ready);
endinterface

### sv/dps_out_if.sv
`timescale 1ns / 1ps
// Output channel: one reconstructed value word per beat.
// No dependencies.
interface dps_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_word;
    logic        end_of_block;

    modport source (output valid, output value_word, output end_of_block,
                    input ready);
    modport sink   (input valid, input value_word, input end_of_block,
                    output ready);
endinterface

### sv/dps_seg_add.sv
`timescale 1ns / 1ps
// Segmented 64-bit adder: eight byte lanes, carry cut at element boundaries.
// Depends on dps_pkg.
module dps_seg_add
    import dps_pkg::*;
(
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  lane_size_t        code,
    output logic [WORD_W-1:0] sum
);

    logic [BYTES_W:0] carry;

    assign carry[0] = 1'b0;

    for (genvar i = 0; i < BYTES_W; i++) begin : g_byte
        logic       cin;
        logic [8:0] s9;

        assign cin = lane_start(code, 3'(i)) ? 1'b0 : carry[i];
        assign s9  = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]} + {8'd0, cin};
        assign sum[8*i +: 8] = s9[7:0];
        assign carry[i+1]    = s9[8];
    end

endmodule

### sv/dps_scan_level.sv
`timescale 1ns / 1ps
// One registered step of the in-word prefix scan: each element adds the one
// 2^LEVEL elements below it. Depends on dps_pkg and dps_seg_add.
module dps_scan_level
    import dps_pkg::*;
#(
    parameter int LEVEL = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  stage_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stage_t dn_data
);

    localparam logic [2:0] LEVEL_W = 3'(LEVEL);

    logic              valid_reg;
    logic              valid_next;
    stage_t            data_reg;
    logic [2:0]        step_sel;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] scanned;

    // distance in bytes is 2^(LEVEL + code); past the word the step is idle
    always_comb
    begin
        step_sel = {1'b0, up_data.code} + LEVEL_W;
        case (step_sel)
            3'd0:    shifted = up_data.data << 8;
            3'd1:    shifted = up_data.data << 16;
            3'd2:    shifted = up_data.data << 32;
            default: shifted = '0;
        endcase
    end

    dps_seg_add u_add (
        .a    (up_data.data),
        .b    (shifted),
        .code (up_data.code),
        .sum  (scanned)
    );

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg.data  <= scanned;
            data_reg.code  <= up_data.code;
            data_reg.first <= up_data.first;
            data_reg.last  <= up_data.last;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### sv/dps_merge.sv
`timescale 1ns / 1ps
// Merge stage: adds the running total to every lane, keeps the top lane as the
// new total and holds the output word. Depends on dps_pkg and dps_seg_add.
module dps_merge
    import dps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  stage_t            up_data,
    output logic              load,
    output logic [WORD_W-1:0] total,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value_word,
    output logic              end_of_block
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] total_reg;
    logic [WORD_W-1:0] total_next;
    logic [WORD_W-1:0] value_reg;
    logic              eob_reg;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] bcast;
    logic [WORD_W-1:0] merged;

    assign seed = up_data.first ? '0 : total_reg;

    // low bits of the total copied into every lane
    always_comb
    begin
        unique case (up_data.code)
            LANE_1B: bcast = {8{seed[7:0]}};
            LANE_2B: bcast = {4{seed[15:0]}};
            LANE_4B: bcast = {2{seed[31:0]}};
            LANE_8B: bcast = seed;
            default: bcast = seed;
        endcase
    end

    dps_seg_add u_add (
        .a    (up_data.data),
        .b    (bcast),
        .code (up_data.code),
        .sum  (merged)
    );

    assign up_ready   = !valid_reg || out_ready;
    assign load       = up_valid && up_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;
    assign total_next = load ? last_lane(merged, up_data.code) : total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= merged;
            eob_reg   <= up_data.last;
        end
    end

    assign total        = total_reg;
    assign out_valid    = valid_reg;
    assign value_word   = value_reg;
    assign end_of_block = eob_reg;

endmodule

### sv/delta_prefix_sum_decoder.sv
`timescale 1ns / 1ps
// Delta prefix-sum decoder, top level.
// delta_in takes one 64-bit word of little-endian deltas per beat, with
// first_word (clear the running total first) and last_word (passed through
// as end_of_block). value_out gives one reconstructed word per input beat,
// in order, with the same lane layout.
// The APB port holds lane_size_code at address 0 (1, 2, 4 or 8 byte lanes);
// write it only while no beat is in flight. pready is tied high.
// Three registered scan steps build prefix sums inside the word, then the
// merge stage adds the running total to every lane. Throughput is one word
// per cycle while the receiver keeps value_out ready; the only loop is the
// single 64-bit running-total add in the merge stage.
// Each stage holds its beat while the stage after it is full, so a stalled
// receiver fills the pipeline; input ready drops once all four stages hold
// a beat. Reset empties the pipeline, zeroes the running total and sets
// byte lanes.
// Depends on dps_pkg, dps_in_if, dps_out_if, dps_scan_level, dps_merge.
module delta_prefix_sum_decoder
    import dps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    dps_in_if.sink            delta_in,
    dps_out_if.source         value_out
);

    lane_size_t        lane_size_reg;
    lane_size_t        lane_size_next;
    logic              cfg_wr;
    stage_t            s0_data;
    stage_t            s1_data;
    stage_t            s2_data;
    stage_t            s3_data;
    logic              s1_valid;
    logic              s2_valid;
    logic              s3_valid;
    logic              s1_ready;
    logic              s2_ready;
    logic              s3_ready;
    logic              mg_load;
    logic [WORD_W-1:0] mg_total;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LANE_SIZE);
    assign lane_size_next = cfg_wr ? lane_size_t'(pwdata[1:0]) : lane_size_reg;
    assign prdata = (paddr[2] == REG_LANE_SIZE) ? {30'd0, lane_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_size_reg <= LANE_1B;
        end
        else
        begin
            lane_size_reg <= lane_size_next;
        end
    end

    assign s0_data.data  = delta_in.delta_word;
    assign s0_data.code  = lane_size_reg;
    assign s0_data.first = delta_in.first_word;
    assign s0_data.last  = delta_in.last_word;

    dps_scan_level #(.LEVEL(0)) u_scan0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (delta_in.valid),
        .up_ready (delta_in.ready),
        .up_data  (s0_data),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    dps_scan_level #(.LEVEL(1)) u_scan1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    dps_scan_level #(.LEVEL(2)) u_scan2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn_data  (s3_data)
    );

    dps_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (s3_valid),
        .up_ready     (s3_ready),
        .up_data      (s3_data),
        .load         (mg_load),
        .total        (mg_total),
        .out_valid    (value_out.valid),
        .out_ready    (value_out.ready),
        .value_word   (value_out.value_word),
        .end_of_block (value_out.end_of_block)
    );

    // running total tracks the top lane of the word just loaded
    a_total_is_top_lane: assert property (@(posedge clk) disable iff (!rst_n)
        mg_load |=> (mg_total == last_lane(value_out.value_word, $past(s3_data.code))))
        else $error("running total differs from top lane of last result");

    // a first word is decoded against a zero total
    a_first_word_zero_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (mg_load && s3_data.first) |=> (value_out.value_word == $past(s3_data.data)))
        else $error("first word not decoded from zero total");

    a_valid_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(value_out.valid) |-> $past(s3_valid))
        else $error("output valid without a beat in the last scan stage");

endmodule

### tb/dps_value_checker.sv
`timescale 1ns / 1ps
// Watches the APB port and both streams of the delta prefix-sum decoder, predicts each
// value word and compares it with the output beats. Depends on dps_pkg, dps_in_if, dps_out_if.
module dps_value_checker
    import dps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    dps_in_if                 delta_in,
    dps_out_if                value_out,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [WORD_W-1:0] value_word;
        logic              end_of_block;
    } value_beat_t;

    value_beat_t       expected_values[$];
    logic [WORD_W-1:0] running_total;
    lane_size_t        lane_code;
    int                fail_tally;

    // inclusive prefix sums per lane, seeded with the carried total
    function automatic logic [WORD_W-1:0] lane_prefix_sums(input logic [WORD_W-1:0] deltas,
                                                           input lane_size_t code,
                                                           input logic [WORD_W-1:0] carry);
        int                lane_bits;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] sums;
        begin
            lane_bits = 8 << int'(code);
            mask = (lane_bits == WORD_W) ? '1 : ((64'd1 << lane_bits) - 64'd1);
            acc  = carry & mask;
            sums = '0;
            for (int i = 0; i < WORD_W / lane_bits; i++) begin
                acc  = (acc + ((deltas >> (i * lane_bits)) & mask)) & mask;
                sums = sums | (acc << (i * lane_bits));
            end
            return sums;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t mismatch on %s: got %h want %h", $realtime, what, got, want);
        fail_tally++;
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        value_beat_t       want;
        logic [WORD_W-1:0] sums;
        int                lane_bits;
        if (!rst_n) begin
            running_total = '0;
            lane_code     = LANE_1B;
            fail_tally    = 0;
            expected_values.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (value_out.valid && value_out.ready) begin
                if (expected_values.size() == 0)
                    report_mismatch("beat with nothing expected", value_out.value_word, '0);
                else begin
                    want = expected_values.pop_front();
                    if (value_out.value_word !== want.value_word)
                        report_mismatch("value_word", value_out.value_word, want.value_word);
                    if (value_out.end_of_block !== want.end_of_block)
                        report_mismatch("end_of_block", 64'(value_out.end_of_block),
                                        64'(want.end_of_block));
                end
            end
            if (delta_in.valid && delta_in.ready) begin
                lane_bits = 8 << int'(lane_code);
                sums = lane_prefix_sums(delta_in.delta_word, lane_code,
                                        delta_in.first_word ? '0 : running_total);
                // new total is the top lane, zero-extended
                running_total = sums >> (WORD_W - lane_bits);
                expected_values.push_back('{sums, delta_in.last_word});
            end
            if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_LANE_SIZE)
                lane_code = lane_size_t'(pwdata[1:0]);
            mismatches  <= fail_tally;
            outstanding <= expected_values.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the delta prefix-sum decoder: directed words, then random
// blocks over several lane sizes. Depends on dps_pkg, the stream interfaces, dps_value_checker.
module tb;
    import dps_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 600;
    localparam logic [APB_AW-1:0] ADDR_LANE_SIZE = {REG_LANE_SIZE, 2'b00};
    // the one index past the register map
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED  = {~REG_LANE_SIZE, 2'b00};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;
    int unsigned       cycle_count;
    bit                gaps_on;

    dps_in_if  delta_ch();
    dps_out_if value_ch();

    delta_prefix_sum_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .delta_in  (delta_ch),
        .value_out (value_ch)
    );

    dps_value_checker u_values (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .delta_in    (delta_ch),
        .value_out   (value_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 19) < 16)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] pick_deltas();
        logic [63:0] w;
        begin
            w = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                3: w = ~(64'd1 << $urandom_range(0, 63));
                4: w = w & 64'h0303_0303_0303_0303;
                default: ;
            endcase
            return w;
        end
    endfunction

    // receiver back-pressure
    initial
    begin
        value_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                value_ch.ready <= 1'b1;
                repeat ($urandom_range(40, 120)) @(posedge clk);
            end
            else
            begin
                value_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                value_ch.ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // valid is left high on return so back-to-back beats need no second assignment
    task automatic push_word(input logic [63:0] deltas, input logic first, input logic last);
        int gap;
        begin
            gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
            if (gap > 0)
            begin
                delta_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            delta_ch.valid      <= 1'b1;
            delta_ch.delta_word <= deltas;
            delta_ch.first_word <= first;
            delta_ch.last_word  <= last;
            @(posedge clk);
            while (!delta_ch.ready) @(posedge clk);
        end
    endtask

    task automatic settle();
        delta_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // idle with psel low so a following write starts on a fresh edge
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        lane_size_t  seq[4];
        lane_size_t  code;
        logic [31:0] junk;
        int          sent;
        int          phase;
        int          phase_words;
        int          blen;
        logic        first;
        logic        last;

        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        delta_ch.valid      <= 1'b0;
        delta_ch.delta_word <= '0;
        delta_ch.first_word <= 1'b0;
        delta_ch.last_word  <= 1'b0;
        gaps_on = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte lanes from reset, then each size written once the stream has drained
        seq = '{LANE_8B, LANE_2B, LANE_4B, LANE_1B};
        for (int s = 0; s <= 4; s++)
        begin
            if (s > 0)
            begin
                settle();
                junk = $urandom;
                junk[1:0] = seq[s-1];
                write_reg(ADDR_LANE_SIZE, junk);
            end
            push_word('1, 1'b0, 1'b0);
            push_word('0, 1'b1, 1'b0);
            push_word(64'h0102_0408_1020_4080, 1'b0, 1'b1);
            push_word('1, 1'b1, 1'b1);
        end
        // a write past the map must leave the lane size alone
        settle();
        write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        push_word(64'h8080_8080_8080_8080, 1'b0, 1'b0);
        push_word(64'h7F7F_7F7F_7F7F_7F7F, 1'b0, 1'b1);

        // random blocks, a fresh lane size per phase
        sent  = 0;
        phase = 0;
        seq   = '{LANE_8B, LANE_1B, LANE_4B, LANE_2B};
        while (sent < RANDOM_WORDS)
        begin
            settle();
            code = (phase < 4) ? seq[phase] : lane_size_t'($urandom_range(0, 3));
            junk = $urandom;
            junk[1:0] = code;
            write_reg(ADDR_LANE_SIZE, junk);
            if ($urandom_range(0, 5) == 0)
                write_reg(ADDR_UNMAPPED, $urandom);
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_words = $urandom_range(30, 90);
            for (int n = 0; n < phase_words; n += blen)
            begin
                blen = $urandom_range(1, 12);
                for (int w = 0; w < blen; w++)
                begin
                    first = (w == 0);
                    last  = (w == blen - 1);
                    // carry the total across the size change now and then
                    if (n == 0 && w == 0)
                        first = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 9) == 0)
                    begin
                        first = 1'($urandom_range(0, 1));
                        last  = 1'($urandom_range(0, 1));
                    end
                    push_word(pick_deltas(), first, last);
                    sent++;
                end
            end
            phase++;
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
